[hdl/b2d_pkg.sv]
// shared types and constants for the binary to decimal digit emitter
// no dependencies; used by every module in hdl
package b2d_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;

    // largest value that is split into digits
    localparam int MAG_BITS = 31;
    localparam logic [MAG_BITS-1:0] MAX_MAGNITUDE = 31'h7fff_ffff;

    localparam int DIGIT_BITS = 4;
    localparam int PLACES     = 10;
    localparam int PLACE_BITS = 4;
    localparam logic [PLACE_BITS-1:0] FIRST_PLACE = 4'd0;
    localparam logic [PLACE_BITS-1:0] LAST_PLACE  = 4'd9;

    // nine times the top power of ten needs 34 bits
    localparam int THR_BITS = 34;
    localparam logic [THR_BITS-1:0] POW10 [PLACES] = '{
        34'd1000000000, 34'd100000000, 34'd10000000, 34'd1000000, 34'd100000,
        34'd10000,      34'd1000,      34'd100,      34'd10,      34'd1
    };

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCOUNT_BITS = 2;

    localparam int M_TDATA_BITS = 8;

    typedef struct packed {
        logic [MAG_BITS-1:0] mag;
        logic                oor;
    } item_t;

    typedef struct packed {
        logic [DIGIT_BITS-1:0] digit;
        logic                  last;
        logic                  oor;
    } result_t;

endpackage

[hdl/b2d_front.sv]
// input side: takes values off the slave stream and classifies them
// depends on b2d_pkg
module b2d_front #(
    parameter int VALUE_BITS = b2d_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  q_full,
    output logic                  push,
    output b2d_pkg::item_t        push_item
);
    import b2d_pkg::*;

    logic [63:0] raw_ext;

    assign raw_ext  = 64'(value);
    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // negative, or larger than MAX_MAGNITUDE
    assign push_item.oor = value[VALUE_BITS-1] || (raw_ext > 64'(MAX_MAGNITUDE));
    assign push_item.mag = raw_ext[MAG_BITS-1:0];

endmodule

[hdl/b2d_queue.sv]
// two-entry queue between the classifier and the digit unit
// depends on b2d_pkg
module b2d_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b2d_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output b2d_pkg::item_t q_item
);
    import b2d_pkg::*;

    item_t                  mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_next;
    logic [QCOUNT_BITS-1:0] count_reg;
    logic [QCOUNT_BITS-1:0] count_next;

    assign full    = (count_reg == QCOUNT_BITS'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hdl/b2d_back.sv]
// digit unit: one decimal place per cycle while the output slot is free, most significant first, with output register
// depends on b2d_pkg
module b2d_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  b2d_pkg::item_t   q_item,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output b2d_pkg::result_t out_result
);
    import b2d_pkg::*;

    logic                  busy_reg;
    logic                  busy_next;
    logic                  oor_reg;
    logic                  started_reg;
    logic [MAG_BITS-1:0]   rest_reg;
    logic [PLACE_BITS-1:0] place_reg;
    logic                  out_valid_reg;
    result_t               out_reg;

    logic [THR_BITS-1:0]   rest_ext;
    logic [THR_BITS-1:0]   thr [1:9];
    logic [9:1]            ge;
    logic [THR_BITS-1:0]   sel;
    logic [DIGIT_BITS-1:0] digit;
    logic                  at_last;
    logic                  slot_free;
    logic                  emit;
    logic                  step;
    logic                  finish;

    assign rest_ext = THR_BITS'(rest_reg);

    // compare the remainder against every multiple of the current place at once
    always_comb
    begin
        sel = '0;
        for (int k = 1; k <= 9; k++)
        begin
            thr[k] = THR_BITS'(k) * POW10[place_reg];
            ge[k]  = (rest_ext >= thr[k]);
            if (ge[k])
            begin
                sel = thr[k];
            end
        end
    end

    assign digit     = DIGIT_BITS'($countones(ge));
    assign at_last   = (place_reg == LAST_PLACE);
    assign slot_free = !out_valid_reg || out_ready;
    // leading zeros are skipped and need no output slot
    assign emit      = oor_reg || (digit != '0) || started_reg || at_last;
    assign step      = busy_reg && (slot_free || !emit);
    assign finish    = step && (oor_reg || at_last);
    assign pop       = q_valid && (!busy_reg || finish);

    always_comb
    begin
        busy_next = busy_reg;
        if (pop)
        begin
            busy_next = 1'b1;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (step && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rest_reg    <= q_item.mag;
            oor_reg     <= q_item.oor;
            place_reg   <= FIRST_PLACE;
            started_reg <= 1'b0;
        end
        else if (step)
        begin
            rest_reg    <= rest_reg - sel[MAG_BITS-1:0];
            place_reg   <= place_reg + 1'b1;
            started_reg <= started_reg || (digit != '0);
        end

        if (step && emit)
        begin
            if (oor_reg)
            begin
                out_reg.digit <= '0;
                out_reg.last  <= 1'b1;
                out_reg.oor   <= 1'b1;
            end
            else
            begin
                out_reg.digit <= digit;
                out_reg.last  <= at_last;
                out_reg.oor   <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

[hdl/binary_to_decimal_digit_emitter.sv]
// top level: signed binary value in, decimal digits out, most significant first
// place 0 is the billions and place 9 the units; an out-of-range value gives a single result, marked last
// the digit unit handles one decimal place per cycle while the output slot is free
// a two-entry queue lets the input side keep accepting while digits are still being emitted
// asynchronous active-low reset empties the queue, idles the digit unit and drops the output
module binary_to_decimal_digit_emitter #(
    parameter int VALUE_BITS = b2d_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]  s_tdata,   // value
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [b2d_pkg::M_TDATA_BITS-1:0] m_tdata,   // digit
    output logic                             m_tlast,
    output logic [0:0]                       m_tuser    // out_of_range
);
    import b2d_pkg::*;

    logic    q_full;
    logic    push;
    item_t   push_item;
    logic    pop;
    logic    q_valid;
    item_t   q_item;
    result_t result;

    b2d_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .value     (s_tdata[VALUE_BITS-1:0]),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    b2d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    b2d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata    = M_TDATA_BITS'(result.digit);
    assign m_tlast    = result.last;
    assign m_tuser[0] = result.oor;

endmodule
